// File: rtl/core/dle_pkg.sv
// shared types and constants for the dns label encoder
package dle_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 6;

  localparam logic [DATA_W-1:0] DOT_CHAR = 8'h2E;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } dle_state_t;

  typedef struct packed {
    logic             load;
    logic             shift;
    logic [CNT_W-1:0] wr_pos;
  } dle_chain_ctl_t;

endpackage

// File: rtl/core/dns_label_encoder.sv
// top level of the dns label encoder: byte chain plus flush control
//
// in channel: one character per item in in_tdata; in_tlast high marks the end
// of the name and carries no character. A non-dot character is stored and
// gives nothing. A dot or an end item gives a run: one length byte, then the
// held label bytes. out_tlast marks the last byte of each run, out_tuser[0]
// the last byte of the whole name, out_tuser[1] every byte of a label that was
// cut to MAX_LABEL bytes.
// the length byte is registered and appears in the cycle after the dot or end item.
// a character item is accepted whenever the output register is free; a dot
// or end item with a held label stops the input until its run has drained,
// as the label drains one byte per cycle, stalls aside, from the chain head.
// reset clears the label count, the overflow flag and the output valid flag.
// when the receiver stalls, the output register holds its item, the chain
// stops shifting and the input side stops accepting items until it is taken.
module dns_label_encoder #(
  parameter int MAX_LABEL = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dle_pkg::DATA_W-1:0] in_tdata,   // in_byte
  input  logic                       in_tlast,   // in_end
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dle_pkg::DATA_W-1:0] out_tdata,  // out_byte
  output logic                       out_tlast,  // run_last
  output logic [1:0]                 out_tuser   // name_done, label_overflow
);
  import dle_pkg::*;

  dle_chain_ctl_t    chain_ctl;
  logic [DATA_W-1:0] cell_q [MAX_LABEL:0];

  assign cell_q[MAX_LABEL] = '0;

  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    dle_cell u_cell (
      .clk       (clk),
      .load      (chain_ctl.load && (chain_ctl.wr_pos == CNT_W'(i))),
      .load_data (in_tdata),
      .shift     (chain_ctl.shift),
      .next_data (cell_q[i+1]),
      .data_q    (cell_q[i])
    );
  end

  dle_ctrl #(
    .MAX_LABEL (MAX_LABEL)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .head_data  (cell_q[0]),
    .chain_ctl  (chain_ctl)
  );

endmodule

// File: rtl/core/dle_cell.sv
// one byte cell of the label chain: loads a new byte or takes its neighbor's
module dle_cell (
  input  logic                       clk,
  input  logic                       load,
  input  logic [dle_pkg::DATA_W-1:0] load_data,
  input  logic                       shift,
  input  logic [dle_pkg::DATA_W-1:0] next_data,
  output logic [dle_pkg::DATA_W-1:0] data_q
);
  import dle_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: rtl/core/dle_ctrl.sv
// control of the dns label encoder: fill count, flush sequencer, output register
module dle_ctrl #(
  parameter int MAX_LABEL = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dle_pkg::DATA_W-1:0] in_tdata,
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dle_pkg::DATA_W-1:0] out_tdata,
  output logic                       out_tlast,
  output logic [1:0]                 out_tuser,
  input  logic [dle_pkg::DATA_W-1:0] head_data,
  output dle_pkg::dle_chain_ctl_t    chain_ctl
);
  import dle_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LABEL);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  dle_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic              flush_done_r, flush_done_nxt;
  logic              flush_ovf_r, flush_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic slot_free;
  logic acc;
  logic is_flush;
  logic wr;
  logic start;
  logic shift;

  assign slot_free = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_flush  = in_tlast || (in_tdata == DOT_CHAR);
  assign wr        = acc && !is_flush && (count_r < MAX_CNT);
  assign start     = acc && is_flush;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (count_r != '0)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (slot_free && (count_r == ONE_CNT)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    shift     = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = slot_free;
      ST_FLUSH: shift     = slot_free;
      default: begin
        in_tready = 1'b0;
        shift     = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    ovf_seen_nxt   = ovf_seen_r;
    flush_done_nxt = flush_done_r;
    flush_ovf_nxt  = flush_ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_ovf_nxt    = out_ovf_r;
    if (wr) begin
      count_nxt = count_r + ONE_CNT;
    end
    if (acc && !is_flush && !(count_r < MAX_CNT)) begin
      ovf_seen_nxt = 1'b1;
    end
    if (start) begin
      // length byte; count now counts bytes still to send
      flush_done_nxt = in_tlast;
      flush_ovf_nxt  = ovf_seen_r;
      ovf_seen_nxt   = 1'b0;
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = DATA_W'(count_r);
      out_last_nxt   = (count_r == '0);
      out_done_nxt   = in_tlast && (count_r == '0);
      out_ovf_nxt    = ovf_seen_r;
    end
    if (shift) begin
      count_nxt     = count_r - ONE_CNT;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = head_data;
      out_last_nxt  = (count_r == ONE_CNT);
      out_done_nxt  = flush_done_r && (count_r == ONE_CNT);
      out_ovf_nxt   = flush_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ovf_seen_r   <= 1'b0;
      flush_done_r <= 1'b0;
      flush_ovf_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
      flush_done_r <= flush_done_nxt;
      flush_ovf_r  <= flush_ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign chain_ctl.load   = wr;
  assign chain_ctl.shift  = shift;
  assign chain_ctl.wr_pos = count_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_done_r};

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (count_r != '0))
    else $error("flush with empty label");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("label count beyond store depth");

  a_no_load_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    !(chain_ctl.load && chain_ctl.shift))
    else $error("chain load and shift together");

  a_flush_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (shift && (count_r == ONE_CNT)) |=> (out_tvalid && out_tlast))
    else $error("final flushed byte not marked last");

  a_done_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("name end without run end");

endmodule
